FILE: design/encoder_position_speed_pwm_top_macros.svh
// Assertion helpers for the design file that checks itself.
`ifndef ENCODER_POSITION_SPEED_PWM_TOP_MACROS_SVH
`define ENCODER_POSITION_SPEED_PWM_TOP_MACROS_SVH

// Checked on every rising clk_i edge, switched off while rst_ni is low.
`define EPS_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every rising clk_i edge, reset included.
`define EPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

FILE: design/eps_pkg.sv
package eps_pkg;

  localparam int GAIN_FRACTION_BITS = 16;

  localparam int COUNT_W = 32;
  localparam int SHORT_W = 16;
  localparam int LONG_W  = 20;
  localparam int GAIN_W  = 24;
  localparam int DUTY_W  = 16;

  // Signed width that holds a position plus a full-range delta plus the modulus.
  localparam int RING_W = COUNT_W + 2;
  localparam int PROD_W = COUNT_W + GAIN_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [SHORT_W-1:0] SHORT_MODULUS_RST = SHORT_W'(980);
  localparam logic [LONG_W-1:0]  LONG_MODULUS_RST  = LONG_W'(9800);
  localparam logic [GAIN_W-1:0]  SPEED_GAIN_RST    = GAIN_W'(9138077);
  localparam logic [GAIN_W-1:0]  SHORT_GAIN_RST    = GAIN_W'(4382523);
  localparam logic [GAIN_W-1:0]  LONG_GAIN_RST     = GAIN_W'(438252);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHORT_MODULUS = 3'd0,
    REG_LONG_MODULUS  = 3'd1,
    REG_SPEED_GAIN    = 3'd2,
    REG_SHORT_GAIN    = 3'd3,
    REG_LONG_GAIN     = 3'd4
  } cfg_reg_e;

  // Work carried from the position update stage to the duty stage.
  typedef struct packed {
    logic [COUNT_W-1:0] diff;
    logic [COUNT_W-1:0] magnitude;
    logic [SHORT_W-1:0] short_pos;
    logic [LONG_W-1:0]  long_pos;
  } stage_t;

endpackage

FILE: design/eps_in_if.sv
interface eps_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [eps_pkg::COUNT_W-1:0] encoder_count;

  modport source (output valid, output encoder_count, input ready);
  modport sink (input valid, input encoder_count, output ready);
endinterface

FILE: design/eps_out_if.sv
interface eps_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [eps_pkg::COUNT_W-1:0] step_delta;
  logic        [eps_pkg::DUTY_W-1:0]  speed_duty;
  logic        [eps_pkg::DUTY_W-1:0]  short_duty;
  logic        [eps_pkg::DUTY_W-1:0]  long_duty;
  logic                               moving_forward;
  logic                               moving_reverse;

  modport source (output valid, output step_delta, output speed_duty, output short_duty,
                  output long_duty, output moving_forward, output moving_reverse,
                  input ready);
  modport sink (input valid, input step_delta, input speed_duty, input short_duty,
                input long_duty, input moving_forward, input moving_reverse,
                output ready);
endinterface

FILE: design/eps_cfg_if.sv
interface eps_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [eps_pkg::CFG_IDX_W-1:0]     index;
  logic [eps_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/eps_ring.sv
module eps_ring (
  input  logic [eps_pkg::LONG_W-1:0]  pos_i,
  input  logic [eps_pkg::COUNT_W-1:0] delta_i,
  input  logic [eps_pkg::LONG_W-1:0]  modulus_i,
  output logic [eps_pkg::LONG_W-1:0]  pos_o
);

  logic signed [eps_pkg::RING_W-1:0] sum;
  logic signed [eps_pkg::RING_W-1:0] modulus;
  logic signed [eps_pkg::RING_W-1:0] wrapped;
  logic signed [eps_pkg::RING_W-1:0] clamped;

  always_comb begin
    sum = $signed({{(eps_pkg::RING_W-eps_pkg::LONG_W){1'b0}}, pos_i})
        + $signed({{(eps_pkg::RING_W-eps_pkg::COUNT_W){delta_i[eps_pkg::COUNT_W-1]}},
                   delta_i});
    modulus = $signed({{(eps_pkg::RING_W-eps_pkg::LONG_W){1'b0}}, modulus_i});

    // The modulus value itself is a legal position, so only values above it wrap.
    if (sum > modulus) begin
      wrapped = sum - modulus;
    end else if (sum < 0) begin
      wrapped = sum + modulus;
    end else begin
      wrapped = sum;
    end

    // A large step can leave the ring out of range after one correction.
    if (wrapped > modulus) begin
      clamped = modulus;
    end else if (wrapped < 0) begin
      clamped = '0;
    end else begin
      clamped = wrapped;
    end

    pos_o = clamped[eps_pkg::LONG_W-1:0];
  end

endmodule

FILE: design/eps_duty_scale.sv
module eps_duty_scale (
  input  logic [eps_pkg::COUNT_W-1:0] value_i,
  input  logic [eps_pkg::GAIN_W-1:0]  gain_i,
  output logic [eps_pkg::DUTY_W-1:0]  duty_o
);

  logic [eps_pkg::PROD_W-1:0] product;

  always_comb begin
    product = eps_pkg::PROD_W'(value_i) * eps_pkg::PROD_W'(gain_i);
    if (|product[eps_pkg::PROD_W-1:eps_pkg::GAIN_FRACTION_BITS+eps_pkg::DUTY_W]) begin
      duty_o = '1;
    end else begin
      duty_o = product[eps_pkg::GAIN_FRACTION_BITS+eps_pkg::DUTY_W-1:
                       eps_pkg::GAIN_FRACTION_BITS];
    end
  end

endmodule

FILE: design/encoder_position_speed_pwm_top.sv
// Encoder count to position, speed and PWM duty.
// in_i carries one sample of the free-running 32-bit quadrature count per beat.
// Each sample yields exactly one beat on out_o: the wrapped difference from the
// previous sample, speed, short-ring and ten-turn-ring duties and direction flags.
// cfg_i writes the two ring moduli and the three Q16 gains; it is always ready
// and should only be used while no sample is in flight.
// A sample is registered in the first stage when accepted and then in the output
// register, from which out_o offers it.
// The first stage does the count difference and both ring updates, the second
// does the three duty multiplies and saturation. One sample can be accepted
// every cycle while out_o takes its results.
// Reset clears the previous count and both ring positions, loads the default
// moduli and gains and empties the pipeline.
// When out_o stalls, the result is held in the output register, the next sample
// waits in the first stage and in_i.ready drops only once both stages are full.
`include "encoder_position_speed_pwm_top_macros.svh"

module encoder_position_speed_pwm_top (
  input  logic clk_i,
  input  logic rst_ni,
  eps_in_if.sink    in_i,
  eps_out_if.source out_o,
  eps_cfg_if.sink   cfg_i
);

  logic [eps_pkg::SHORT_W-1:0] short_mod_q;
  logic [eps_pkg::LONG_W-1:0]  long_mod_q;
  logic [eps_pkg::GAIN_W-1:0]  speed_gain_q;
  logic [eps_pkg::GAIN_W-1:0]  short_gain_q;
  logic [eps_pkg::GAIN_W-1:0]  long_gain_q;

  logic [eps_pkg::COUNT_W-1:0] prev_count_q;
  logic [eps_pkg::SHORT_W-1:0] short_pos_q;
  logic [eps_pkg::LONG_W-1:0]  long_pos_q;

  logic                        in_acc;
  logic                        cfg_acc;
  logic                        s1_ready;
  logic                        s2_ready;
  logic                        s1_valid_q;
  eps_pkg::stage_t             s1_d;
  eps_pkg::stage_t             s1_q;
  logic [eps_pkg::LONG_W-1:0]  short_new;
  logic [eps_pkg::LONG_W-1:0]  long_new;

  logic                        out_valid_q;
  logic [eps_pkg::COUNT_W-1:0] out_delta_q;
  logic [eps_pkg::DUTY_W-1:0]  out_speed_q;
  logic [eps_pkg::DUTY_W-1:0]  out_short_q;
  logic [eps_pkg::DUTY_W-1:0]  out_long_q;
  logic                        out_fwd_q;
  logic                        out_rev_q;
  logic [eps_pkg::DUTY_W-1:0]  speed_duty;
  logic [eps_pkg::DUTY_W-1:0]  short_duty;
  logic [eps_pkg::DUTY_W-1:0]  long_duty;

  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;

  assign s2_ready   = !out_valid_q || out_o.ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_i.ready = s1_ready;
  assign in_acc     = in_i.valid && s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_mod_q  <= eps_pkg::SHORT_MODULUS_RST;
      long_mod_q   <= eps_pkg::LONG_MODULUS_RST;
      speed_gain_q <= eps_pkg::SPEED_GAIN_RST;
      short_gain_q <= eps_pkg::SHORT_GAIN_RST;
      long_gain_q  <= eps_pkg::LONG_GAIN_RST;
    end else if (cfg_acc) begin
      case (cfg_i.index)
        eps_pkg::REG_SHORT_MODULUS: short_mod_q  <= cfg_i.data[eps_pkg::SHORT_W-1:0];
        eps_pkg::REG_LONG_MODULUS:  long_mod_q   <= cfg_i.data[eps_pkg::LONG_W-1:0];
        eps_pkg::REG_SPEED_GAIN:    speed_gain_q <= cfg_i.data[eps_pkg::GAIN_W-1:0];
        eps_pkg::REG_SHORT_GAIN:    short_gain_q <= cfg_i.data[eps_pkg::GAIN_W-1:0];
        eps_pkg::REG_LONG_GAIN:     long_gain_q  <= cfg_i.data[eps_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage one: difference, magnitude and both ring updates.
  always_comb begin
    s1_d.diff = in_i.encoder_count - prev_count_q;
    // Negating the most negative difference gives 2^31 as an unsigned magnitude.
    s1_d.magnitude = s1_d.diff[eps_pkg::COUNT_W-1] ? (~s1_d.diff + 1'b1) : s1_d.diff;
    s1_d.short_pos = short_new[eps_pkg::SHORT_W-1:0];
    s1_d.long_pos  = long_new;
  end

  eps_ring u_short_ring (
    .pos_i     ({{(eps_pkg::LONG_W-eps_pkg::SHORT_W){1'b0}}, short_pos_q}),
    .delta_i   (s1_d.diff),
    .modulus_i ({{(eps_pkg::LONG_W-eps_pkg::SHORT_W){1'b0}}, short_mod_q}),
    .pos_o     (short_new)
  );

  eps_ring u_long_ring (
    .pos_i     (long_pos_q),
    .delta_i   (s1_d.diff),
    .modulus_i (long_mod_q),
    .pos_o     (long_new)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_count_q <= '0;
      short_pos_q  <= '0;
      long_pos_q   <= '0;
    end else if (in_acc) begin
      prev_count_q <= in_i.encoder_count;
      short_pos_q  <= s1_d.short_pos;
      long_pos_q   <= s1_d.long_pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
  end

  // Stage two: the three duty multiplies and saturation.
  eps_duty_scale u_speed_scale (
    .value_i (s1_q.magnitude),
    .gain_i  (speed_gain_q),
    .duty_o  (speed_duty)
  );

  eps_duty_scale u_short_scale (
    .value_i ({{(eps_pkg::COUNT_W-eps_pkg::SHORT_W){1'b0}}, s1_q.short_pos}),
    .gain_i  (short_gain_q),
    .duty_o  (short_duty)
  );

  eps_duty_scale u_long_scale (
    .value_i ({{(eps_pkg::COUNT_W-eps_pkg::LONG_W){1'b0}}, s1_q.long_pos}),
    .gain_i  (long_gain_q),
    .duty_o  (long_duty)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      out_delta_q <= s1_q.diff;
      out_speed_q <= speed_duty;
      out_short_q <= short_duty;
      out_long_q  <= long_duty;
      out_fwd_q   <= !s1_q.diff[eps_pkg::COUNT_W-1] && (|s1_q.diff);
      out_rev_q   <= s1_q.diff[eps_pkg::COUNT_W-1];
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.step_delta     = out_delta_q;
  assign out_o.speed_duty     = out_speed_q;
  assign out_o.short_duty     = out_short_q;
  assign out_o.long_duty      = out_long_q;
  assign out_o.moving_forward = out_fwd_q;
  assign out_o.moving_reverse = out_rev_q;

  `EPS_ASSERT_CLK(a_accept_fills_stage, in_acc |=> s1_valid_q,
                  "accepted beat lost in stage one")
  `EPS_ASSERT_CLK(a_short_in_range, in_acc |=> (short_pos_q <= $past(short_mod_q)),
                  "short ring out of range")
  `EPS_ASSERT_CLK(a_long_in_range, in_acc |=> (long_pos_q <= $past(long_mod_q)),
                  "long ring out of range")
  `EPS_ASSERT_CLK(a_flags_excl, out_valid_q |-> !(out_fwd_q && out_rev_q),
                  "both direction flags set")
  `EPS_ASSERT_CLK(a_still_no_flag,
                  (out_valid_q && (out_delta_q == '0)) |-> !(out_fwd_q || out_rev_q),
                  "direction flag with zero delta")
  `EPS_ASSERT_ALWAYS(a_ready_when_room, !s1_valid_q |-> in_i.ready,
                     "input stalled with empty stage")

endmodule

FILE: verif/eps_checker.sv
module eps_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  eps_in_if           in_mon,
  eps_out_if          out_mon,
  eps_cfg_if          cfg_mon,
  output int unsigned errors_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import eps_pkg::*;

  localparam logic [DUTY_W-1:0] DUTY_MAX = {DUTY_W{1'b1}};

  typedef struct packed {
    logic signed [COUNT_W-1:0] step_delta;
    logic [DUTY_W-1:0]         speed_duty;
    logic [DUTY_W-1:0]         short_duty;
    logic [DUTY_W-1:0]         long_duty;
    logic                      moving_forward;
    logic                      moving_reverse;
  } motion_t;

  logic [SHORT_W-1:0] short_modulus;
  logic [LONG_W-1:0]  long_modulus;
  logic [GAIN_W-1:0]  speed_gain;
  logic [GAIN_W-1:0]  short_gain;
  logic [GAIN_W-1:0]  long_gain;

  logic [COUNT_W-1:0] last_count;
  logic [SHORT_W-1:0] short_pos;
  logic [LONG_W-1:0]  long_pos;

  motion_t     pending_motions[$];
  int unsigned mismatches;

  // One correction back into range, then clamp whatever is still outside it.
  function automatic longint wrap_ring(input longint pos, input longint delta,
                                       input longint modulus);
    longint sum;
    sum = pos + delta;
    if (sum > modulus) begin
      sum = sum - modulus;
    end else if (sum < 0) begin
      sum = sum + modulus;
    end
    if (sum > modulus) begin
      sum = modulus;
    end else if (sum < 0) begin
      sum = 0;
    end
    return sum;
  endfunction

  function automatic logic [DUTY_W-1:0] scale_to_duty(input longint unsigned value,
                                                      input logic [GAIN_W-1:0] gain);
    longint unsigned scaled;
    scaled = (value * 64'(gain)) >> GAIN_FRACTION_BITS;
    return (scaled > 64'(DUTY_MAX)) ? DUTY_MAX : scaled[DUTY_W-1:0];
  endfunction

  function automatic motion_t advance_encoder(input logic [COUNT_W-1:0] count);
    motion_t         beat;
    logic [COUNT_W-1:0] diff;
    longint          delta;
    longint unsigned magnitude;
    diff      = count - last_count;
    delta     = longint'($signed(diff));
    magnitude = diff[COUNT_W-1] ? 64'(-delta) : 64'(delta);
    last_count = count;
    short_pos = SHORT_W'(wrap_ring(longint'(short_pos), delta, longint'(short_modulus)));
    long_pos  = LONG_W'(wrap_ring(longint'(long_pos), delta, longint'(long_modulus)));
    beat.step_delta     = diff;
    beat.speed_duty     = scale_to_duty(magnitude, speed_gain);
    beat.short_duty     = scale_to_duty(64'(short_pos), short_gain);
    beat.long_duty      = scale_to_duty(64'(long_pos), long_gain);
    beat.moving_forward = !diff[COUNT_W-1] && (diff != '0);
    beat.moving_reverse = diff[COUNT_W-1];
    return beat;
  endfunction

  task automatic check_field(input string label, input logic [COUNT_W-1:0] want,
                             input logic [COUNT_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_modulus = SHORT_MODULUS_RST;
      long_modulus  = LONG_MODULUS_RST;
      speed_gain    = SPEED_GAIN_RST;
      short_gain    = SHORT_GAIN_RST;
      long_gain     = LONG_GAIN_RST;
      last_count    = '0;
      short_pos     = '0;
      long_pos      = '0;
      pending_motions.delete();
      mismatches = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      motion_t seen;
      motion_t want;
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_SHORT_MODULUS: short_modulus = cfg_mon.data[SHORT_W-1:0];
          REG_LONG_MODULUS:  long_modulus  = cfg_mon.data[LONG_W-1:0];
          REG_SPEED_GAIN:    speed_gain    = cfg_mon.data[GAIN_W-1:0];
          REG_SHORT_GAIN:    short_gain    = cfg_mon.data[GAIN_W-1:0];
          REG_LONG_GAIN:     long_gain     = cfg_mon.data[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        seen.step_delta     = out_mon.step_delta;
        seen.speed_duty     = out_mon.speed_duty;
        seen.short_duty     = out_mon.short_duty;
        seen.long_duty      = out_mon.long_duty;
        seen.moving_forward = out_mon.moving_forward;
        seen.moving_reverse = out_mon.moving_reverse;
        if (pending_motions.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with nothing expected, expected none, got %0h",
                   $time, seen);
        end else begin
          want = pending_motions.pop_front();
          check_field("step_delta", want.step_delta, seen.step_delta);
          check_field("speed_duty", COUNT_W'(want.speed_duty), COUNT_W'(seen.speed_duty));
          check_field("short_duty", COUNT_W'(want.short_duty), COUNT_W'(seen.short_duty));
          check_field("long_duty", COUNT_W'(want.long_duty), COUNT_W'(seen.long_duty));
          check_field("moving_forward", COUNT_W'(want.moving_forward),
                      COUNT_W'(seen.moving_forward));
          check_field("moving_reverse", COUNT_W'(want.moving_reverse),
                      COUNT_W'(seen.moving_reverse));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        pending_motions.push_back(advance_encoder(in_mon.encoder_count));
      end
      errors_o  <= mismatches;
      pending_o <= pending_motions.size();
    end
  end

endmodule

FILE: verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import eps_pkg::*;

  typedef enum int {
    CFG_DEFAULTS,
    CFG_RANDOM,
    CFG_SMALLEST,
    CFG_ZERO_MODULI,
    CFG_LARGEST,
    CFG_SHRUNK,
    CFG_NO_GAIN,
    CFG_RANDOM_SMALL,
    CFG_COUNT
  } setting_e;

  localparam int ITEMS_PER_SETTING = 100;
  localparam int LONG_HOLD         = 300;
  localparam int DRAIN_CYCLES      = 6;
  localparam int CYCLE_LIMIT       = 400000;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = CFG_IDX_W'(REG_LONG_GAIN) + 1'b1;
  localparam logic [GAIN_W-1:0] GAIN_MAX = {GAIN_W{1'b1}};

  // Walks both rings onto their bounds, past them, and through the sign and
  // magnitude corners of the 32-bit difference.
  localparam logic [COUNT_W-1:0] DIRECTED_COUNTS [18] = '{
    32'h0000_0000, 32'd980, 32'd981, 32'd979, 32'd5979, 32'hFFFF_C93B,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
    32'h0000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAB, 32'hAAAA_AAAA,
    32'hAAAA_AC80, 32'hAAAA_AE57
  };

  logic clk_i;
  logic rst_ni;

  eps_in_if  in_bus ();
  eps_out_if out_bus ();
  eps_cfg_if cfg_bus ();

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 25;
  int unsigned recv_idle_pct = 73;
  int unsigned span = 980;
  bit          hold_req = 1'b0;
  logic [COUNT_W-1:0] last_sent = '0;

  encoder_position_speed_pwm_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  eps_checker i_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (in_bus),
    .out_mon   (out_bus),
    .cfg_mon   (cfg_bus),
    .errors_o  (fail_count),
    .pending_o (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Result side: random back-pressure, or one long hold-off on request.
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_bus.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
      end else begin
        out_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_sample(input logic [COUNT_W-1:0] count);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk_i);
      in_bus.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_bus.valid         <= 1'b1;
    in_bus.encoder_count <= count;
    do @(posedge clk_i); while (!in_bus.ready);
    last_sent = count;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk_i); while (!cfg_bus.ready);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_setting(input setting_e setting);
    logic [SHORT_W-1:0] short_mod;
    case (setting)
      CFG_RANDOM: begin
        short_mod = SHORT_W'($urandom_range(1, 65535));
        span = 32'(short_mod);
        write_reg(REG_SHORT_MODULUS, CFG_DATA_W'(short_mod));
        write_reg(REG_LONG_MODULUS, $urandom_range(1, 1048575));
        write_reg(REG_SPEED_GAIN, $urandom);
        write_reg(REG_SHORT_GAIN, $urandom);
        write_reg(REG_LONG_GAIN, $urandom);
        // Indexes past the register list must leave everything untouched.
        for (int idx = int'(REG_FIRST_UNUSED); idx < 2 ** CFG_IDX_W; idx++) begin
          write_reg(CFG_IDX_W'(idx), $urandom);
        end
      end
      CFG_SMALLEST: begin
        span = 4;
        write_reg(REG_SHORT_MODULUS, 1);
        write_reg(REG_LONG_MODULUS, 1);
        write_reg(REG_SPEED_GAIN, CFG_DATA_W'(GAIN_MAX));
        write_reg(REG_SHORT_GAIN, CFG_DATA_W'(GAIN_MAX));
        write_reg(REG_LONG_GAIN, CFG_DATA_W'(GAIN_MAX));
      end
      CFG_ZERO_MODULI: begin
        // Only bits above the register width are set, so both moduli become zero.
        span = 500;
        write_reg(REG_SHORT_MODULUS, 32'h0001_0000);
        write_reg(REG_LONG_MODULUS, 32'h0010_0000);
        write_reg(REG_SPEED_GAIN, $urandom);
        write_reg(REG_SHORT_GAIN, $urandom);
        write_reg(REG_LONG_GAIN, $urandom);
      end
      CFG_LARGEST: begin
        span = 65535;
        write_reg(REG_SHORT_MODULUS, 65535);
        write_reg(REG_LONG_MODULUS, 1048575);
        write_reg(REG_SPEED_GAIN, CFG_DATA_W'(GAIN_MAX));
        write_reg(REG_SHORT_GAIN, CFG_DATA_W'(GAIN_MAX));
        write_reg(REG_LONG_GAIN, CFG_DATA_W'(GAIN_MAX));
      end
      CFG_SHRUNK: begin
        // The rings still hold large positions from the previous setting.
        span = 7;
        write_reg(REG_SHORT_MODULUS, 7);
        write_reg(REG_LONG_MODULUS, 13);
        write_reg(REG_SPEED_GAIN, $urandom);
        write_reg(REG_SHORT_GAIN, $urandom);
        write_reg(REG_LONG_GAIN, $urandom);
      end
      CFG_NO_GAIN: begin
        span = 980;
        write_reg(REG_SHORT_MODULUS, CFG_DATA_W'(SHORT_MODULUS_RST));
        write_reg(REG_LONG_MODULUS, CFG_DATA_W'(LONG_MODULUS_RST));
        write_reg(REG_SPEED_GAIN, 0);
        write_reg(REG_SHORT_GAIN, 0);
        write_reg(REG_LONG_GAIN, 0);
      end
      CFG_RANDOM_SMALL: begin
        short_mod = SHORT_W'($urandom_range(1, 64));
        span = 32'(short_mod);
        write_reg(REG_SHORT_MODULUS, CFG_DATA_W'(short_mod));
        write_reg(REG_LONG_MODULUS, $urandom_range(1, 640));
        write_reg(REG_SPEED_GAIN, $urandom);
        write_reg(REG_SHORT_GAIN, $urandom);
        write_reg(REG_LONG_GAIN, $urandom);
      end
      default: ;
    endcase
  endtask

  initial begin
    rst_ni               = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.encoder_count = '0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.index        = '0;
    cfg_bus.data         = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int setting = CFG_DEFAULTS; setting < CFG_COUNT; setting++) begin
      if (setting != CFG_DEFAULTS) begin
        wait_drained();
        load_setting(setting_e'(setting));
      end
      if (setting <= CFG_SMALLEST) begin
        send_idle_pct = 25;
        recv_idle_pct = 73;
      end else if (setting <= CFG_SHRUNK) begin
        send_idle_pct = 73;
        recv_idle_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (setting == CFG_DEFAULTS) begin
        foreach (DIRECTED_COUNTS[i]) send_sample(DIRECTED_COUNTS[i]);
      end
      // With no idling on the sender, this hold-off fills the pipeline.
      if (setting == CFG_NO_GAIN) hold_req = 1'b1;
      repeat (ITEMS_PER_SETTING) begin
        logic [COUNT_W-1:0] sample;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          sample = last_sent + ($urandom_range(0, 4 * span) - 2 * span);
        end else if (pick < 75) begin
          sample = last_sent + ($urandom_range(0, 2 ** 21) - 2 ** 20);
        end else if (pick < 90) begin
          sample = $urandom;
        end else begin
          case ($urandom_range(0, 4))
            0: sample = last_sent;
            1: sample = last_sent + 1;
            2: sample = last_sent - 1;
            3: sample = last_sent + 32'h8000_0000;
            default: sample = last_sent + span;
          endcase
        end
        send_sample(sample);
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule
